// File: sv/mmp_pkg.sv
package mmp_pkg;

  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [7:0]  FuncRead  = 8'h03;
  localparam logic [7:0]  RegCount  = 8'h1A;
  localparam logic [7:0]  DataBytes = 8'd52;
  localparam logic [7:0]  AddrReset = 8'd1;

  localparam int unsigned FrameLen      = 57;
  localparam int unsigned HeadLen       = 3;
  localparam int unsigned StoreLen      = 48;
  localparam int unsigned StoreAw       = $clog2(StoreLen);
  localparam int unsigned CmdLen        = 8;
  localparam int unsigned CmdCrcBytes   = 6;
  localparam int unsigned NumFields     = 20;
  localparam int unsigned NumShort      = 16;
  localparam int unsigned CmdQueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ERROR = 2'd2
  } out_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_ADDR  = 3'd1,
    ERR_FUNC  = 3'd2,
    ERR_COUNT = 3'd3,
    ERR_CRC   = 3'd4
  } err_code_e;

  typedef enum logic [1:0] {
    CMD_POLL   = 2'd0,
    CMD_FIELDS = 2'd1,
    CMD_ERROR  = 2'd2
  } cmd_kind_e;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_POLL,
    BE_READ,
    BE_SHIFT,
    BE_EMIT,
    BE_ERR
  } be_state_e;

  typedef struct packed {
    cmd_kind_e kind;
    err_code_e err;
  } cmd_t;

  typedef struct packed {
    logic               en;
    logic [StoreAw-1:0] addr;
    logic [7:0]         data;
  } store_wr_t;

  typedef struct packed {
    out_kind_e   kind;
    logic [7:0]  tx_byte;
    logic [4:0]  field_index;
    logic [31:0] raw_value;
    err_code_e   error_code;
    logic        last;
  } res_t;

  // One byte of reflected CRC-16 (eight shift steps on 16 bits).
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/modbus_meter_poll_frame_engine_unit.sv
// Modbus RTU poll engine for a three-phase meter. Push one beat per input: req_type_i high
// starts a poll and yields eight command beats (address, 0x03, 0x0000, 0x001A, CRC low,
// CRC high); req_type_i low hands over one received serial byte. After the 57th reply byte
// the engine yields either 20 raw field beats in frame order or one error beat; bytes that
// arrive with no poll outstanding are taken and dropped. An input beat is taken whenever full
// is low; a poll drains at one beat per cycle while pop keeps up, and a good frame drains
// through the payload store's single read port, each byte passing a read and a shift state
// and each field an emit state. full stays high from the last reply byte of a good frame
// until the store has been read out, and otherwise only when the two-entry job queue between
// the receive front and the output sequencer is full. Write device_address only while idle.

module modbus_meter_poll_frame_engine_unit #(
  parameter int unsigned CmdQueueDepth = mmp_pkg::CmdQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [7:0]  rx_byte_i,
  // result beats
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [4:0]  field_index_o,
  output logic [31:0] raw_value_o,
  output logic [2:0]  error_code_o,
  output logic        last_o,
  // device_address write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import mmp_pkg::*;

  logic [7:0] dev_addr_q;
  logic       q_full, q_empty, q_push, q_pop;
  cmd_t       q_wdata, q_rdata;
  store_wr_t  st_wr;
  logic       release_store;
  res_t       res;

  // Hold the slave address; the channel never back-pressures.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= AddrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dev_addr_q <= cfg_data_i;
    end
  end

  // Front: classify beats, run the reply CRC and header checks, fill the store.
  mmp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .req_type_i (req_type_i),
    .rx_byte_i  (rx_byte_i),
    .dev_addr_i (dev_addr_q),
    .release_i  (release_store),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .st_wr_o    (st_wr)
  );

  // Job queue: poll, field dump or error report.
  mmp_cmd_fifo #(
    .Depth (CmdQueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // Back: emit the command, walk the store into fields, or report the error.
  mmp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dev_addr_i (dev_addr_q),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .st_wr_i    (st_wr),
    .release_o  (release_store),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res)
  );

  assign out_kind_o    = res.kind;
  assign tx_byte_o     = res.tx_byte;
  assign field_index_o = res.field_index;
  assign raw_value_o   = res.raw_value;
  assign error_code_o  = res.error_code;
  assign last_o        = res.last;

endmodule

// File: sv/mmp_front.sv
module mmp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic                req_type_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [7:0]          dev_addr_i,
  input  logic                release_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output mmp_pkg::cmd_t       q_data_o,
  output mmp_pkg::store_wr_t  st_wr_o
);
  import mmp_pkg::*;

  logic        armed_q, armed_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  low_q, low_d;
  err_code_e   err_q, err_d;
  logic        hold_q, hold_d;
  logic        accept;
  logic [15:0] crc_next;
  err_code_e   fin_err;

  assign full_o   = q_full_i || hold_q;
  assign accept   = push_i && !full_o;
  assign crc_next = crc_byte(crc_q, rx_byte_i);

  always_comb begin
    armed_d  = armed_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    low_d    = low_q;
    err_d    = err_q;
    hold_d   = hold_q;
    q_push_o = 1'b0;
    q_data_o = '{kind: CMD_POLL, err: ERR_NONE};
    st_wr_o  = '{en: 1'b0, addr: StoreAw'(cnt_q - 6'(HeadLen)), data: rx_byte_i};
    fin_err  = ERR_NONE;

    if (accept) begin
      if (req_type_i) begin
        // restart reception, drop whatever was in flight
        q_push_o = 1'b1;
        armed_d  = 1'b1;
        cnt_d    = '0;
        crc_d    = CrcInit;
        low_d    = '0;
        err_d    = ERR_NONE;
      end else if (armed_q) begin
        if (cnt_q < 6'(FrameLen - 2)) crc_d = crc_next;
        if (err_q == ERR_NONE) begin
          if (cnt_q == 6'd0 && rx_byte_i != dev_addr_i) err_d = ERR_ADDR;
          if (cnt_q == 6'd1 && rx_byte_i != FuncRead)   err_d = ERR_FUNC;
          if (cnt_q == 6'd2 && rx_byte_i != DataBytes)  err_d = ERR_COUNT;
        end
        if (cnt_q >= 6'(HeadLen) && cnt_q < 6'(HeadLen + StoreLen)) st_wr_o.en = 1'b1;
        if (cnt_q == 6'(FrameLen - 2)) low_d = rx_byte_i;

        if (cnt_q < 6'(FrameLen - 1)) begin
          cnt_d = cnt_q + 6'd1;
        end else begin
          armed_d  = 1'b0;
          cnt_d    = '0;
          fin_err  = ({rx_byte_i, low_q} != crc_q) ? ERR_CRC : err_q;
          q_push_o = 1'b1;
          if (fin_err == ERR_NONE) begin
            q_data_o = '{kind: CMD_FIELDS, err: ERR_NONE};
            hold_d   = 1'b1;
          end else begin
            q_data_o = '{kind: CMD_ERROR, err: fin_err};
          end
        end
      end
    end

    if (release_i) hold_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      cnt_q   <= '0;
      crc_q   <= CrcInit;
      low_q   <= '0;
      err_q   <= ERR_NONE;
      hold_q  <= 1'b0;
    end else begin
      armed_q <= armed_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      low_q   <= low_d;
      err_q   <= err_d;
      hold_q  <= hold_d;
    end
  end

endmodule

// File: sv/mmp_cmd_fifo.sv
module mmp_cmd_fifo #(
  parameter int unsigned Depth = mmp_pkg::CmdQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mmp_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output mmp_pkg::cmd_t data_o,
  output logic          empty_o
);
  import mmp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      if (do_pop)  rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

// File: sv/mmp_back.sv
module mmp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         dev_addr_i,
  input  logic               q_empty_i,
  input  mmp_pkg::cmd_t      q_data_i,
  output logic               q_pop_o,
  input  mmp_pkg::store_wr_t st_wr_i,
  output logic               release_o,
  output logic               empty_o,
  input  logic               pop_i,
  output mmp_pkg::res_t      res_o
);
  import mmp_pkg::*;

  logic [7:0]         mem_q [StoreLen];
  logic [7:0]         rdata_q;

  be_state_e          state_q, state_d;
  logic [2:0]         idx_q, idx_d;
  logic [15:0]        crc_q, crc_d;
  logic [StoreAw-1:0] ptr_q, ptr_d;
  logic [4:0]         fld_q, fld_d;
  logic [1:0]         bcnt_q, bcnt_d;
  logic [31:0]        acc_q, acc_d;
  err_code_e          err_q, err_d;
  logic               ov_q, ov_d;
  res_t               res_q, res_d;
  logic               slot_free;
  logic [7:0]         cmd_byte;
  logic [1:0]         fld_last_byte;

  assign slot_free     = !ov_q || pop_i;
  assign empty_o       = !ov_q;
  assign res_o         = res_q;
  assign fld_last_byte = (fld_q < 5'(NumShort)) ? 2'd1 : 2'd3;

  always_comb begin
    case (idx_q)
      3'd0:    cmd_byte = dev_addr_i;
      3'd1:    cmd_byte = FuncRead;
      3'd5:    cmd_byte = RegCount;
      3'd6:    cmd_byte = crc_q[7:0];
      3'd7:    cmd_byte = crc_q[15:8];
      default: cmd_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    crc_d     = crc_q;
    ptr_d     = ptr_q;
    fld_d     = fld_q;
    bcnt_d    = bcnt_q;
    acc_d     = acc_q;
    err_d     = err_q;
    q_pop_o   = 1'b0;
    release_o = 1'b0;
    ov_d      = ov_q && !pop_i;
    res_d     = res_q;

    unique case (state_q)
      BE_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          unique case (q_data_i.kind)
            CMD_POLL: begin
              idx_d   = '0;
              crc_d   = CrcInit;
              state_d = BE_POLL;
            end
            CMD_FIELDS: begin
              ptr_d   = '0;
              fld_d   = '0;
              bcnt_d  = '0;
              acc_d   = '0;
              state_d = BE_READ;
            end
            default: begin
              err_d   = q_data_i.err;
              state_d = BE_ERR;
            end
          endcase
        end
      end
      BE_POLL: begin
        if (slot_free) begin
          ov_d  = 1'b1;
          res_d = '{kind: KIND_TX, tx_byte: cmd_byte, field_index: '0, raw_value: '0,
                    error_code: ERR_NONE, last: (idx_q == 3'(CmdLen - 1))};
          if (idx_q < 3'(CmdCrcBytes)) crc_d = crc_byte(crc_q, cmd_byte);
          if (idx_q == 3'(CmdLen - 1)) state_d = BE_IDLE;
          else idx_d = idx_q + 3'd1;
        end
      end
      BE_READ: begin
        state_d = BE_SHIFT;
      end
      BE_SHIFT: begin
        acc_d = {acc_q[23:0], rdata_q};
        if (ptr_q != StoreAw'(StoreLen - 1)) ptr_d = ptr_q + StoreAw'(1);
        if (bcnt_q == fld_last_byte) begin
          bcnt_d  = '0;
          state_d = BE_EMIT;
        end else begin
          bcnt_d  = bcnt_q + 2'd1;
          state_d = BE_READ;
        end
      end
      BE_EMIT: begin
        if (slot_free) begin
          ov_d  = 1'b1;
          res_d = '{kind: KIND_FIELD, tx_byte: '0, field_index: fld_q, raw_value: acc_q,
                    error_code: ERR_NONE, last: (fld_q == 5'(NumFields - 1))};
          acc_d = '0;
          if (fld_q == 5'(NumFields - 1)) begin
            release_o = 1'b1;
            state_d   = BE_IDLE;
          end else begin
            fld_d   = fld_q + 5'd1;
            state_d = BE_READ;
          end
        end
      end
      BE_ERR: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          res_d   = '{kind: KIND_ERROR, tx_byte: '0, field_index: '0, raw_value: '0,
                      error_code: err_q, last: 1'b1};
          state_d = BE_IDLE;
        end
      end
      default: state_d = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_wr_i.en) mem_q[st_wr_i.addr] <= st_wr_i.data;
    rdata_q <= mem_q[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    crc_q  <= crc_d;
    ptr_q  <= ptr_d;
    fld_q  <= fld_d;
    bcnt_q <= bcnt_d;
    acc_q  <= acc_d;
    err_q  <= err_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// File: sv/mmp_checker.sv
module mmp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  out_kind_o,
  input logic [7:0]  tx_byte_o,
  input logic [4:0]  field_index_o,
  input logic [31:0] raw_value_o,
  input logic [2:0]  error_code_o,
  input logic        last_o
);
  import mmp_pkg::*;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(raw_value_o) && $stable(out_kind_o)
      && $stable(tx_byte_o) && $stable(last_o))
    else $error("stalled result beat changed");

  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_kind_o == KIND_TX |->
      raw_value_o == 32'd0 && field_index_o == 5'd0 && error_code_o == ERR_NONE)
    else $error("command beat carries field or error data");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_kind_o == KIND_ERROR |-> last_o && error_code_o != ERR_NONE)
    else $error("error beat without code or not last");

  a_field_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_kind_o == KIND_FIELD |->
      last_o == (field_index_o == 5'(NumFields - 1)) && error_code_o == ERR_NONE)
    else $error("field beat last flag does not match final field");

endmodule

bind modbus_meter_poll_frame_engine_unit mmp_checker u_mmp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .out_kind_o    (out_kind_o),
  .tx_byte_o     (tx_byte_o),
  .field_index_o (field_index_o),
  .raw_value_o   (raw_value_o),
  .error_code_o  (error_code_o),
  .last_o        (last_o)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mmp_pkg::*;

  typedef enum int {
    FR_GOOD,
    FR_BAD_ADDR,
    FR_BAD_FUNC,
    FR_BAD_COUNT,
    FR_BAD_CRC
  } frame_kind_e;

  typedef logic [7:0] reply_t [FrameLen];

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic        req_type_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        empty;
  logic        pop         = 1'b0;
  logic [1:0]  out_kind_o;
  logic [7:0]  tx_byte_o;
  logic [4:0]  field_index_o;
  logic [31:0] raw_value_o;
  logic [2:0]  error_code_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i  = 8'h00;

  // Mirror of the engine state, advanced on every accepted input beat.
  logic [7:0]  dev_addr = AddrReset;
  logic        rx_armed = 1'b0;
  int          rx_count = 0;
  logic [15:0] rx_crc = CrcInit;
  logic [7:0]  rx_crc_lo = 8'h00;
  err_code_e   rx_err = ERR_NONE;
  logic [7:0]  payload [StoreLen];

  res_t expected_beats [$];
  res_t want;
  int   fails = 0;
  bit   send_steady = 1'b0;
  bit   pop_steady = 1'b0;

  modbus_meter_poll_frame_engine_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type_i),
    .rx_byte_i    (rx_byte_i),
    .empty        (empty),
    .pop          (pop),
    .out_kind_o   (out_kind_o),
    .tx_byte_o    (tx_byte_o),
    .field_index_o(field_index_o),
    .raw_value_o  (raw_value_o),
    .error_code_o (error_code_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Bit-serial form of the reflected CRC-16: feed LSB first.
  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ d[k];
      r  = r >> 1;
      if (fb) r = r ^ CrcPoly;
    end
    return r;
  endfunction

  function automatic void add_beat(out_kind_e kind, logic [7:0] tx, logic [4:0] idx,
                                   logic [31:0] raw, err_code_e err, logic lst);
    res_t b;
    b.kind        = kind;
    b.tx_byte     = tx;
    b.field_index = idx;
    b.raw_value   = raw;
    b.error_code  = err;
    b.last        = lst;
    expected_beats.push_back(b);
  endfunction

  // Work out the beats that one accepted input causes.
  function automatic void predict_input(logic req, logic [7:0] b);
    logic [7:0]  cmd [CmdLen];
    logic [15:0] c;
    logic [15:0] got_crc;
    err_code_e   e;
    logic [31:0] v;
    int          n;
    int          o;
    if (req) begin
      cmd = '{dev_addr, FuncRead, 8'h00, 8'h00, 8'h00, RegCount, 8'h00, 8'h00};
      c = CrcInit;
      for (int i = 0; i < CmdCrcBytes; i++) c = crc16_step(c, cmd[i]);
      cmd[6] = c[7:0];
      cmd[7] = c[15:8];
      for (int i = 0; i < CmdLen; i++)
        add_beat(KIND_TX, cmd[i], 5'd0, 32'd0, ERR_NONE, i == CmdLen - 1);
      rx_armed  = 1'b1;
      rx_count  = 0;
      rx_crc    = CrcInit;
      rx_crc_lo = 8'h00;
      rx_err    = ERR_NONE;
      return;
    end
    // Drop bytes with no poll outstanding.
    if (!rx_armed) return;
    n = rx_count;
    if (n < FrameLen - 2) rx_crc = crc16_step(rx_crc, b);
    if (n == 0 && b != dev_addr && rx_err == ERR_NONE) rx_err = ERR_ADDR;
    if (n == 1 && b != FuncRead && rx_err == ERR_NONE) rx_err = ERR_FUNC;
    if (n == 2 && b != DataBytes && rx_err == ERR_NONE) rx_err = ERR_COUNT;
    if (n >= HeadLen && n < HeadLen + StoreLen) payload[n - HeadLen] = b;
    if (n == FrameLen - 2) rx_crc_lo = b;
    if (n < FrameLen - 1) begin
      rx_count = n + 1;
      return;
    end
    // Closing CRC byte: a CRC fault wins over the first header fault.
    rx_armed = 1'b0;
    rx_count = 0;
    got_crc  = {b, rx_crc_lo};
    e = (got_crc != rx_crc) ? ERR_CRC : rx_err;
    if (e != ERR_NONE) begin
      add_beat(KIND_ERROR, 8'h00, 5'd0, 32'd0, e, 1'b1);
      return;
    end
    for (int k = 0; k < NumShort; k++) begin
      v = {16'h0000, payload[2 * k], payload[2 * k + 1]};
      add_beat(KIND_FIELD, 8'h00, 5'(k), v, ERR_NONE, 1'b0);
    end
    for (int k = 0; k < NumFields - NumShort; k++) begin
      o = 2 * NumShort + 4 * k;
      v = {payload[o], payload[o + 1], payload[o + 2], payload[o + 3]};
      add_beat(KIND_FIELD, 8'h00, 5'(NumShort + k), v, ERR_NONE,
               k == NumFields - NumShort - 1);
    end
  endfunction

  // Mostly short gaps, now and then a long one; none in steady mode.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [7:0] other_than(logic [7:0] v);
    logic [7:0] w;
    do w = 8'($urandom_range(0, 255)); while (w == v);
    return w;
  endfunction

  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Build one 57-byte reply for the current address, broken as the kind says.
  function automatic void build_reply(input frame_kind_e kind, output reply_t reply);
    logic [15:0] c;
    reply[0] = dev_addr;
    reply[1] = FuncRead;
    reply[2] = DataBytes;
    for (int i = HeadLen; i < FrameLen - 2; i++) reply[i] = payload_byte();
    case (kind)
      FR_BAD_ADDR: begin
        reply[0] = other_than(dev_addr);
        if ($urandom_range(0, 1) == 1) reply[1] = other_than(FuncRead);
      end
      FR_BAD_FUNC: begin
        reply[1] = other_than(FuncRead);
        if ($urandom_range(0, 1) == 1) reply[2] = other_than(DataBytes);
      end
      FR_BAD_COUNT: begin
        reply[2] = other_than(DataBytes);
      end
      FR_BAD_CRC: begin
        // CRC fault wins over any header fault in the same frame.
        if ($urandom_range(0, 1) == 1) begin
          c = 16'($urandom_range(0, 2));
          reply[c] = other_than(reply[c]);
        end
      end
      default: ;
    endcase
    c = CrcInit;
    for (int i = 0; i < FrameLen - 2; i++) c = crc16_step(c, reply[i]);
    if (kind == FR_BAD_CRC) c = c ^ 16'($urandom_range(1, 65535));
    reply[FrameLen - 2] = c[7:0];
    reply[FrameLen - 1] = c[15:8];
  endfunction

  // Offer one input beat, hold it until taken, then predict its results.
  // push is left high; a gap before the next beat or a drain lowers it.
  task automatic send_beat(logic req, logic [7:0] b);
    int gap;
    gap = pick_gap(send_steady);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    req_type_i <= req;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (full);
    predict_input(req, b);
  endtask

  // Stop offering beats, let every expected result arrive, then let the
  // engine settle on trailing bytes that cause no result.
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_address(logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dev_addr = v;
  endtask

  task automatic test_idle_bytes();
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, 8'h5A);
    wait_drained();
  endtask

  // Command frames at the reset address and at both address extremes,
  // and a poll issued while the previous one is still armed.
  task automatic test_poll_commands();
    send_beat(1'b1, 8'h00);
    wait_drained();
    write_address(8'h00);
    send_beat(1'b1, 8'hFF);
    wait_drained();
    write_address(8'hFF);
    send_beat(1'b1, 8'($urandom_range(0, 255)));
    send_beat(1'b1, 8'h00);
    wait_drained();
  endtask

  // Abandon a reply partway through with a fresh poll, then finish the frame.
  task automatic test_abandoned_reply();
    reply_t reply;
    write_address(8'h01);
    build_reply(FR_GOOD, reply);
    send_beat(1'b1, 8'h00);
    for (int i = 0; i < 5; i++) send_beat(1'b0, reply[i]);
    send_beat(1'b1, 8'h00);
    for (int i = 0; i < FrameLen; i++) send_beat(1'b0, reply[i]);
    wait_drained();
  endtask

  // Whole replies with random payloads; each outcome shows up at least once.
  task automatic test_reply_frames();
    frame_kind_e pending [$];
    frame_kind_e kind;
    reply_t      reply;
    int          sent;
    int          idx;
    int          r;
    int          cut;
    pending = '{FR_GOOD, FR_BAD_ADDR, FR_BAD_FUNC, FR_BAD_COUNT, FR_BAD_CRC};
    sent = 0;
    while (sent < 210 || pending.size() != 0) begin
      if (pending.size() != 0) begin
        idx  = $urandom_range(0, pending.size() - 1);
        kind = pending[idx];
        pending.delete(idx);
      end else begin
        r    = $urandom_range(0, 9);
        kind = (r < 6) ? FR_GOOD : frame_kind_e'($urandom_range(1, 4));
      end
      send_steady = ($urandom_range(0, 3) == 0);
      pop_steady  = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        wait_drained();
        r = $urandom_range(0, 3);
        write_address(r == 0 ? 8'h00 : r == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
      end
      // Line noise with no poll outstanding.
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_beat(1'b0, 8'($urandom_range(0, 255)));
      build_reply(kind, reply);
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, FrameLen - 1);
        send_beat(1'b1, 8'($urandom_range(0, 255)));
        for (int i = 0; i < cut; i++) send_beat(1'b0, reply[i]);
        sent += cut + 1;
      end
      send_beat(1'b1, 8'($urandom_range(0, 255)));
      for (int i = 0; i < FrameLen; i++) send_beat(1'b0, reply[i]);
      sent += FrameLen + 1;
    end
    wait_drained();
  endtask

  // Result side stalls on its own schedule.
  initial begin
    int gap;
    forever begin
      gap = pick_gap(pop_steady);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  function automatic void flag_mismatch(string name, logic [31:0] exp_v, logic [31:0] got_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    fails++;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected, kind %0d tx %0h idx %0d raw %0h",
                 $time, out_kind_o, tx_byte_o, field_index_o, raw_value_o);
        fails++;
      end else begin
        want = expected_beats.pop_front();
        if (out_kind_o !== want.kind) flag_mismatch("out_kind", want.kind, out_kind_o);
        if (tx_byte_o !== want.tx_byte) flag_mismatch("tx_byte", want.tx_byte, tx_byte_o);
        if (field_index_o !== want.field_index)
          flag_mismatch("field_index", want.field_index, field_index_o);
        if (raw_value_o !== want.raw_value)
          flag_mismatch("raw_value", want.raw_value, raw_value_o);
        if (error_code_o !== want.error_code)
          flag_mismatch("error_code", want.error_code, error_code_o);
        if (last_o !== want.last) flag_mismatch("last", want.last, last_o);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_bytes();
    test_poll_commands();
    test_abandoned_reply();
    test_reply_frames();
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
